@@ hdl/gate_door_pulse_controller_defines.svh @@
// ----------------------------------------------------------------------------
// gate_door_pulse_controller_defines
// Assertion macros for the gate door pulse controller.
// ----------------------------------------------------------------------------
`ifndef GATE_DOOR_PULSE_CONTROLLER_DEFINES_SVH
`define GATE_DOOR_PULSE_CONTROLLER_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication, sampled on clk, off while rst_n is low
`define GDPC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define GDPC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define GDPC_ASSERT_NOW(lbl, ante, cons, msg)
`define GDPC_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

@@ hdl/gdpc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gdpc_pkg
// Types, codes and action tables of the gate door pulse controller.
// ----------------------------------------------------------------------------
package gdpc_pkg;

    localparam int QUEUE_DEPTH = 8;
    localparam int HEAD_W      = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_CMD_DELAY      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WARNING_TIME   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TRAVEL_TIMEOUT = 2'd2;

    localparam logic [15:0] CMD_DELAY_RST      = 16'd500;
    localparam logic [15:0] WARNING_TIME_RST   = 16'd3000;
    localparam logic [31:0] TRAVEL_TIMEOUT_RST = 32'd60000;

    typedef logic [1:0] cmd_t;
    localparam cmd_t CMD_NONE = 2'd0;
    localparam cmd_t CMD_STOP = 2'd1;
    localparam cmd_t CMD_UP   = 2'd2;
    localparam cmd_t CMD_DOWN = 2'd3;

    // bit 0 level, bits 2..1 line
    typedef logic [2:0] act_t;
    localparam act_t ACT_STOP_LO = 3'd0;
    localparam act_t ACT_STOP_HI = 3'd1;
    localparam act_t ACT_WARN_LO = 3'd2;
    localparam act_t ACT_WARN_HI = 3'd3;
    localparam act_t ACT_UP_LO   = 3'd4;
    localparam act_t ACT_UP_HI   = 3'd5;
    localparam act_t ACT_DOWN_LO = 3'd6;
    localparam act_t ACT_DOWN_HI = 3'd7;

    // drive line bit positions
    localparam int LINE_UP_BIT   = 0;
    localparam int LINE_DOWN_BIT = 1;
    localparam int LINE_STOP_BIT = 2;
    localparam int LINE_WARN_BIT = 3;

    typedef logic [1:0] rep_t;
    localparam rep_t REP_OPEN    = 2'd0;
    localparam rep_t REP_CLOSED  = 2'd1;
    localparam rep_t REP_CLOSING = 2'd2;
    localparam rep_t REP_OPENING = 2'd3;

    // queued sequences; every push follows a queue clear
    typedef logic [1:0] seq_t;
    localparam seq_t SEQ_STOP       = 2'd0;
    localparam seq_t SEQ_UP         = 2'd1;
    localparam seq_t SEQ_DOWN_WARN  = 2'd2;
    localparam seq_t SEQ_DOWN_PLAIN = 2'd3;

    function automatic logic [CNT_W-1:0] seq_len(input seq_t seq);
        logic [CNT_W-1:0] len;
        case (seq)
            SEQ_STOP:       len = CNT_W'(2);
            SEQ_UP:         len = CNT_W'(4);
            SEQ_DOWN_WARN:  len = CNT_W'(8);
            SEQ_DOWN_PLAIN: len = CNT_W'(4);
            default:        len = CNT_W'(2);
        endcase
        return len;
    endfunction

    function automatic act_t seq_act(input seq_t seq, input logic [HEAD_W-1:0] idx);
        act_t act;
        int   pos;
        pos = int'(idx);
        act = ACT_STOP_LO;
        case (seq)
            SEQ_UP:
            begin
                case (pos)
                    0:       act = ACT_STOP_HI;
                    1:       act = ACT_STOP_LO;
                    2:       act = ACT_UP_HI;
                    3:       act = ACT_UP_LO;
                    default: act = ACT_STOP_LO;
                endcase
            end
            SEQ_DOWN_WARN:
            begin
                case (pos)
                    0:       act = ACT_STOP_HI;
                    1:       act = ACT_STOP_LO;
                    2:       act = ACT_WARN_HI;
                    3:       act = ACT_WARN_LO;
                    4:       act = ACT_STOP_HI;
                    5:       act = ACT_STOP_LO;
                    6:       act = ACT_DOWN_HI;
                    7:       act = ACT_DOWN_LO;
                    default: act = ACT_STOP_LO;
                endcase
            end
            SEQ_DOWN_PLAIN:
            begin
                case (pos)
                    0:       act = ACT_STOP_HI;
                    1:       act = ACT_STOP_LO;
                    2:       act = ACT_DOWN_HI;
                    3:       act = ACT_DOWN_LO;
                    default: act = ACT_STOP_LO;
                endcase
            end
            default:
            begin
                case (pos)
                    0:       act = ACT_STOP_HI;
                    default: act = ACT_STOP_LO;
                endcase
            end
        endcase
        return act;
    endfunction

    function automatic logic [3:0] line_mask(input act_t act);
        logic [3:0] mask;
        mask = 4'b0000;
        case (act[2:1])
            2'd0:    mask[LINE_STOP_BIT] = 1'b1;
            2'd1:    mask[LINE_WARN_BIT] = 1'b1;
            2'd2:    mask[LINE_UP_BIT]   = 1'b1;
            2'd3:    mask[LINE_DOWN_BIT] = 1'b1;
            default: mask = 4'b0000;
        endcase
        return mask;
    endfunction

    // edge events in report order: up rise, down rise, up fall, down fall
    function automatic rep_t edge_rep(input int idx);
        rep_t rep;
        case (idx)
            0:       rep = REP_OPEN;
            1:       rep = REP_CLOSED;
            2:       rep = REP_CLOSING;
            default: rep = REP_OPENING;
        endcase
        return rep;
    endfunction

endpackage

@@ hdl/gate_door_pulse_controller.sv @@
`timescale 1ns / 1ps
// Path from item accept to result: input register, then result register; out_valid
// rises when the item advances out of the input register, which out_stall can hold.
// Throughput: 1 item per cycle unless out_stall holds a pending result; the result
// register and the queue sequencer update together, so back-to-back ticks run without
// bubbles. Reset: rst_n asynchronous active low; internal line state low, queue empty,
// tick counter zero, configuration at 500 / 3000 / 60000 ms; result fields not reset.
// ----------------------------------------------------------------------------
// gate_door_pulse_controller
// Gate door pulse sequencer with limit switch tracking, one item per tick.
// ----------------------------------------------------------------------------
`include "gate_door_pulse_controller_defines.svh"

module gate_door_pulse_controller
    import gdpc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [1:0]            cmd,
    input  logic                  limit_up,
    input  logic                  limit_down,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic                  drive_up,
    output logic                  drive_down,
    output logic                  drive_stop,
    output logic                  drive_warn,
    output logic                  cmd_ignored,
    output logic [1:0]            report_count,
    output logic [1:0]            first_report,
    output logic [1:0]            second_report
);

    // configuration
    logic [15:0] cmd_delay_reg;
    logic [15:0] warning_time_reg;
    logic [31:0] travel_timeout_reg;

    // input stage
    logic        s1_valid_reg;
    logic        s1_valid_next;
    cmd_t        s1_cmd_reg;
    logic        s1_up_reg;
    logic        s1_down_reg;
    logic        load_in;
    logic        advance;

    // controller state
    logic [31:0]       tick_reg;
    logic              prev_up_reg;
    logic              prev_down_reg;
    logic              travelling_reg;
    logic              travelling_next;
    logic [31:0]       travel_start_reg;
    logic [31:0]       travel_start_next;
    seq_t              seq_reg;
    seq_t              seq_next;
    logic [HEAD_W-1:0] head_reg;
    logic [HEAD_W-1:0] head_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic              started_reg;
    logic              started_next;
    logic [31:0]       pulse_start_reg;
    logic [31:0]       pulse_start_next;
    logic [3:0]        lines_reg;
    logic [3:0]        lines_next;
    logic              prev_hold;

    // command and queue
    logic              take_cmd;
    logic              ignored;
    seq_t              cmd_seq;
    seq_t              q_seq;
    logic [HEAD_W-1:0] q_head;
    logic [CNT_W-1:0]  q_count;
    logic              q_started;
    logic [31:0]       q_start;
    logic [3:0]        q_lines;
    logic [31:0]       elapsed;
    act_t              head_act;
    logic [3:0]        head_mask;
    logic              pop;

    // limit tracking
    logic [31:0] travel_time;
    logic        timeout;
    logic [3:0]  edges;
    logic [1:0]  rep_n;
    rep_t        rep0;
    rep_t        rep1;

    // result register
    logic        out_valid_reg;
    logic        out_valid_next;
    logic [3:0]  res_lines_reg;
    logic        res_ignored_reg;
    logic [1:0]  res_count_reg;
    rep_t        res_rep0_reg;
    rep_t        res_rep1_reg;

    assign advance  = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = s1_valid_reg && !advance;
    assign load_in  = in_valid && !in_stall;

    always_comb
    begin
        if (load_in)
        begin
            s1_valid_next = 1'b1;
        end
        else if (advance)
        begin
            s1_valid_next = 1'b0;
        end
        else
        begin
            s1_valid_next = s1_valid_reg;
        end

        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_stall)
        begin
            out_valid_next = out_valid_reg;
        end
        else
        begin
            out_valid_next = 1'b0;
        end
    end

    // command decode and queue pop
    always_comb
    begin
        take_cmd = 1'b0;
        ignored  = 1'b0;
        cmd_seq  = SEQ_STOP;
        case (s1_cmd_reg)
            CMD_STOP:
            begin
                take_cmd = 1'b1;
            end
            CMD_UP:
            begin
                ignored  = prev_up_reg;
                take_cmd = !prev_up_reg;
                cmd_seq  = SEQ_UP;
            end
            CMD_DOWN:
            begin
                ignored  = prev_down_reg;
                take_cmd = !prev_down_reg;
                cmd_seq  = (warning_time_reg != 16'd0) ? SEQ_DOWN_WARN : SEQ_DOWN_PLAIN;
            end
            default:
            begin
                take_cmd = 1'b0;
            end
        endcase

        q_seq     = take_cmd ? cmd_seq : seq_reg;
        q_head    = take_cmd ? '0 : head_reg;
        q_count   = take_cmd ? seq_len(cmd_seq) : count_reg;
        q_started = take_cmd ? 1'b0 : started_reg;
        q_start   = take_cmd ? 32'd0 : pulse_start_reg;
        q_lines   = take_cmd ? 4'b0000 : lines_reg;

        elapsed   = tick_reg - q_start;
        head_act  = seq_act(q_seq, q_head);
        head_mask = line_mask(head_act);

        pop = (q_count != '0)
            && !(q_started && (elapsed < {16'd0, cmd_delay_reg}))
            && !((head_act == ACT_WARN_LO) && q_started
                 && (elapsed < {16'd0, warning_time_reg}));

        seq_next         = q_seq;
        head_next        = q_head;
        count_next       = q_count;
        started_next     = q_started;
        pulse_start_next = q_start;
        lines_next       = q_lines;
        if (pop)
        begin
            head_next        = q_head + HEAD_W'(1);
            count_next       = q_count - CNT_W'(1);
            started_next     = 1'b1;
            pulse_start_next = tick_reg;
            if (head_act[0])
            begin
                lines_next = q_lines | head_mask;
            end
            else
            begin
                lines_next = q_lines & ~head_mask;
            end
        end
    end

    // limit switch edges and travel timeout
    always_comb
    begin
        prev_hold   = (s1_up_reg && prev_up_reg) || (s1_down_reg && prev_down_reg);
        travel_time = tick_reg - travel_start_reg;
        timeout     = !prev_hold && !s1_up_reg && !prev_up_reg && !s1_down_reg
                    && !prev_down_reg && travelling_reg && (travel_time > travel_timeout_reg);
        edges[0] = !prev_hold && s1_up_reg && !prev_up_reg;
        edges[1] = !prev_hold && s1_down_reg && !prev_down_reg;
        edges[2] = !prev_hold && !s1_up_reg && prev_up_reg;
        edges[3] = !prev_hold && !s1_down_reg && prev_down_reg;

        rep_n = 2'd0;
        rep0  = REP_OPEN;
        rep1  = REP_OPEN;
        if (timeout)
        begin
            rep_n = 2'd1;
        end
        for (int i = 0; i < 4; i++)
        begin
            if (edges[i] && (rep_n != 2'd2))
            begin
                if (rep_n == 2'd0)
                begin
                    rep0 = edge_rep(i);
                end
                else
                begin
                    rep1 = edge_rep(i);
                end
                rep_n = rep_n + 2'd1;
            end
        end

        travelling_next   = travelling_reg;
        travel_start_next = travel_start_reg;
        if (edges[2] || edges[3])
        begin
            travelling_next   = 1'b1;
            travel_start_next = tick_reg;
        end
        else if (timeout || edges[0] || edges[1])
        begin
            travelling_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_delay_reg      <= CMD_DELAY_RST;
            warning_time_reg   <= WARNING_TIME_RST;
            travel_timeout_reg <= TRAVEL_TIMEOUT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_CMD_DELAY:      cmd_delay_reg      <= cfg_data[15:0];
                CFG_WARNING_TIME:   warning_time_reg   <= cfg_data[15:0];
                CFG_TRAVEL_TIMEOUT: travel_timeout_reg <= cfg_data;
                default:            ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            tick_reg         <= 32'd0;
            prev_up_reg      <= 1'b0;
            prev_down_reg    <= 1'b0;
            travelling_reg   <= 1'b0;
            travel_start_reg <= 32'd0;
            seq_reg          <= SEQ_STOP;
            head_reg         <= '0;
            count_reg        <= '0;
            started_reg      <= 1'b0;
            pulse_start_reg  <= 32'd0;
            lines_reg        <= 4'b0000;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                tick_reg         <= tick_reg + 32'd1;
                travelling_reg   <= travelling_next;
                travel_start_reg <= travel_start_next;
                seq_reg          <= seq_next;
                head_reg         <= head_next;
                count_reg        <= count_next;
                started_reg      <= started_next;
                pulse_start_reg  <= pulse_start_next;
                lines_reg        <= lines_next;
                if (!prev_hold)
                begin
                    prev_up_reg   <= s1_up_reg;
                    prev_down_reg <= s1_down_reg;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_in)
        begin
            s1_cmd_reg  <= cmd;
            s1_up_reg   <= limit_up;
            s1_down_reg <= limit_down;
        end
        if (advance)
        begin
            res_lines_reg   <= lines_next;
            res_ignored_reg <= ignored;
            res_count_reg   <= rep_n;
            res_rep0_reg    <= rep0;
            res_rep1_reg    <= rep1;
        end
    end

    assign out_valid     = out_valid_reg;
    assign drive_up      = res_lines_reg[LINE_UP_BIT];
    assign drive_down    = res_lines_reg[LINE_DOWN_BIT];
    assign drive_stop    = res_lines_reg[LINE_STOP_BIT];
    assign drive_warn    = res_lines_reg[LINE_WARN_BIT];
    assign cmd_ignored   = res_ignored_reg;
    assign report_count  = res_count_reg;
    assign first_report  = res_rep0_reg;
    assign second_report = res_rep1_reg;

    `GDPC_ASSERT_NOW(a_queue_bound, 1'b1, count_reg <= CNT_W'(QUEUE_DEPTH), "queue count overflow")
    `GDPC_ASSERT_NOW(a_one_line_high, 1'b1, $onehot0(lines_reg), "more than one drive line high")
    `GDPC_ASSERT_NEXT(a_result_follows, advance, out_valid_reg, "advanced item left no result")

endmodule

@@ sim/gate_door_pulse_controller_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gate_door_pulse_controller_tb
// Self-checking bench for the gate door pulse controller. Ticks go in over a
// valid/stall channel. A behavioral model of the output-change queue and the
// limit-switch tracker predicts every result, and a checker compares each
// result field by field. Directed ticks come first, then randomized door
// traffic under several idle patterns and a long output hold-off.
// ----------------------------------------------------------------------------
module gate_door_pulse_controller_tb;
    import gdpc_pkg::*;

    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 3000;

    typedef struct packed {
        logic       up;
        logic       down;
        logic       stop;
        logic       warn;
        logic       ignored;
        logic [1:0] count;
        rep_t       first;
        rep_t       second;
    } tick_result_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_stall;
    logic [1:0]            cmd;
    logic                  limit_up;
    logic                  limit_down;
    logic                  out_valid;
    logic                  out_stall;
    logic                  drive_up;
    logic                  drive_down;
    logic                  drive_stop;
    logic                  drive_warn;
    logic                  cmd_ignored;
    logic [1:0]            report_count;
    logic [1:0]            first_report;
    logic [1:0]            second_report;

    // model of the block
    logic [15:0] delay_ms;
    logic [15:0] warn_ms;
    logic [31:0] timeout_ms;
    logic [31:0] tick_count;
    logic        last_up;
    logic        last_dn;
    logic        in_travel;
    logic [31:0] travel_t0;
    act_t        act_fifo [QUEUE_DEPTH];
    logic [HEAD_W-1:0] fifo_head;
    int          fifo_used;
    logic        pulse_on;
    logic [31:0] pulse_t0;
    logic [3:0]  lines;

    tick_result_t expected_ticks[$];
    tick_result_t exp_r;

    int   errors = 0;
    int   snd_idle_pct = 0;
    int   rcv_idle_pct = 0;
    int   hold_asked = 0;
    int   hold_taken = 0;
    int   hold_left = 0;
    int   idle_cycles = 0;
    logic door_up = 1'b0;
    logic door_dn = 1'b0;

    gate_door_pulse_controller DUT (.*);

    always #5 clk = ~clk;

    function automatic void fifo_clear();
        fifo_head = '0;
        fifo_used = 0;
        pulse_on  = 1'b0;
        pulse_t0  = '0;
        lines     = '0;
    endfunction

    function automatic void fifo_push(act_t a);
        if (fifo_used < QUEUE_DEPTH)
        begin
            act_fifo[(fifo_head + fifo_used) % QUEUE_DEPTH] = a;
            fifo_used++;
        end
    endfunction

    function automatic void fifo_run();
        logic [31:0] elapsed;
        act_t        a;
        int          bitpos;
        if (fifo_used == 0)
            return;
        elapsed = tick_count - pulse_t0;
        if (pulse_on && elapsed < {16'd0, delay_ms})
            return;
        a = act_fifo[fifo_head];
        if (a == ACT_WARN_LO && pulse_on && elapsed < {16'd0, warn_ms})
            return;
        fifo_head = fifo_head + HEAD_W'(1);
        fifo_used--;
        case (a)
            ACT_STOP_LO, ACT_STOP_HI: bitpos = LINE_STOP_BIT;
            ACT_WARN_LO, ACT_WARN_HI: bitpos = LINE_WARN_BIT;
            ACT_UP_LO, ACT_UP_HI:     bitpos = LINE_UP_BIT;
            default:                  bitpos = LINE_DOWN_BIT;
        endcase
        lines[bitpos] = a[0];
        pulse_on = 1'b1;
        pulse_t0 = tick_count;
    endfunction

    function automatic tick_result_t predict_tick(cmd_t c, logic up, logic dn);
        tick_result_t r;
        rep_t         reps [2];
        int           n;
        n       = 0;
        reps[0] = REP_OPEN;
        reps[1] = REP_OPEN;
        r       = '0;
        if (c == CMD_STOP)
        begin
            fifo_clear();
            fifo_push(ACT_STOP_HI);
            fifo_push(ACT_STOP_LO);
        end
        else if (c == CMD_UP || c == CMD_DOWN)
        begin
            if ((c == CMD_UP && last_up) || (c == CMD_DOWN && last_dn))
                r.ignored = 1'b1;
            else
            begin
                fifo_clear();
                fifo_push(ACT_STOP_HI);
                fifo_push(ACT_STOP_LO);
                if (c == CMD_UP)
                begin
                    fifo_push(ACT_UP_HI);
                    fifo_push(ACT_UP_LO);
                end
                else
                begin
                    if (warn_ms != 16'd0)
                    begin
                        fifo_push(ACT_WARN_HI);
                        fifo_push(ACT_WARN_LO);
                        fifo_push(ACT_STOP_HI);
                        fifo_push(ACT_STOP_LO);
                    end
                    fifo_push(ACT_DOWN_HI);
                    fifo_push(ACT_DOWN_LO);
                end
            end
        end
        fifo_run();
        // a switch held high freezes tracking and the stored samples
        if (!((up && last_up) || (dn && last_dn)))
        begin
            if (!up && !last_up && !dn && !last_dn && in_travel
                && (tick_count - travel_t0) > timeout_ms)
            begin
                in_travel = 1'b0;
                reps[n] = REP_OPEN;
                n++;
            end
            if (up && !last_up)
            begin
                in_travel = 1'b0;
                if (n < 2)
                begin
                    reps[n] = REP_OPEN;
                    n++;
                end
            end
            if (dn && !last_dn)
            begin
                in_travel = 1'b0;
                if (n < 2)
                begin
                    reps[n] = REP_CLOSED;
                    n++;
                end
            end
            if (!up && last_up)
            begin
                in_travel = 1'b1;
                travel_t0 = tick_count;
                if (n < 2)
                begin
                    reps[n] = REP_CLOSING;
                    n++;
                end
            end
            if (!dn && last_dn)
            begin
                in_travel = 1'b1;
                travel_t0 = tick_count;
                if (n < 2)
                begin
                    reps[n] = REP_OPENING;
                    n++;
                end
            end
            last_up = up;
            last_dn = dn;
        end
        tick_count = tick_count + 32'd1;
        r.up     = lines[LINE_UP_BIT];
        r.down   = lines[LINE_DOWN_BIT];
        r.stop   = lines[LINE_STOP_BIT];
        r.warn   = lines[LINE_WARN_BIT];
        r.count  = 2'(n);
        r.first  = reps[0];
        r.second = reps[1];
        return r;
    endfunction

    function automatic void check_field(string name, int exp_v, int got_v);
        if (exp_v != got_v)
        begin
            errors++;
            $display("%0t: %s expected %0d actual %0d", $time, name, exp_v, got_v);
        end
    endfunction

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_ticks.size() == 0)
            begin
                errors++;
                $display("%0t: result with no item pending", $time);
            end
            else
            begin
                exp_r = expected_ticks.pop_front();
                check_field("drive_up", exp_r.up, drive_up);
                check_field("drive_down", exp_r.down, drive_down);
                check_field("drive_stop", exp_r.stop, drive_stop);
                check_field("drive_warn", exp_r.warn, drive_warn);
                check_field("cmd_ignored", exp_r.ignored, cmd_ignored);
                check_field("report_count", exp_r.count, report_count);
                check_field("first_report", exp_r.first, first_report);
                check_field("second_report", exp_r.second, second_report);
            end
        end
    end

    // receiver stall, with a long hold when asked
    always @(negedge clk)
    begin
        if (hold_taken != hold_asked)
        begin
            hold_taken = hold_asked;
            hold_left  = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < rcv_idle_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: watchdog expired, %0d results pending", $time,
                         expected_ticks.size());
                $display("tb: failure");
                $finish;
            end
        end
    end

    task automatic send_tick(cmd_t c, logic up, logic dn);
        while ($urandom_range(99) < snd_idle_pct)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid   <= 1'b1;
        cmd        <= c;
        limit_up   <= up;
        limit_down <= dn;
        do
            @(posedge clk);
        while (!(in_valid && !in_stall));
        expected_ticks.push_back(predict_tick(c, up, dn));
    endtask

    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_ticks.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        case (idx)
            CFG_CMD_DELAY:    delay_ms   = val[15:0];
            CFG_WARNING_TIME: warn_ms    = val[15:0];
            default:          timeout_ms = val;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_config(logic [15:0] d, logic [15:0] w, logic [31:0] t);
        drain();
        write_cfg(CFG_CMD_DELAY, {16'd0, d});
        write_cfg(CFG_WARNING_TIME, {16'd0, w});
        write_cfg(CFG_TRAVEL_TIMEOUT, t);
    endtask

    // door traffic: mostly quiet ticks, switches move now and then
    task automatic random_ticks(int n);
        int   r;
        cmd_t c;
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(99);
            if (r < 72)
                c = CMD_NONE;
            else if (r < 80)
                c = CMD_STOP;
            else if (r < 90)
                c = CMD_UP;
            else
                c = CMD_DOWN;
            r = $urandom_range(99);
            if (r < 5)
            begin
                case ($urandom_range(2))
                    0:       {door_up, door_dn} = 2'b10;
                    1:       {door_up, door_dn} = 2'b00;
                    default: {door_up, door_dn} = 2'b01;
                endcase
            end
            else if (r < 7)
                {door_up, door_dn} = 2'($urandom_range(3));
            send_tick(c, door_up, door_dn);
        end
    endtask

    task automatic test_reset_values();
        send_tick(CMD_STOP, 1'b0, 1'b0);
        send_tick(CMD_DOWN, 1'b0, 1'b0);
    endtask

    task automatic test_directed();
        set_config(16'd1, 16'd2, 32'd3);
        send_tick(CMD_UP, 1'b0, 1'b0);
        send_tick(CMD_DOWN, 1'b0, 1'b0);
        send_tick(CMD_NONE, 1'b1, 1'b0);
        send_tick(CMD_UP, 1'b1, 1'b0);
        send_tick(CMD_NONE, 1'b0, 1'b1);
        send_tick(CMD_DOWN, 1'b0, 1'b1);
        send_tick(CMD_NONE, 1'b1, 1'b0);
        send_tick(CMD_NONE, 1'b1, 1'b1);
        send_tick(CMD_NONE, 1'b0, 1'b0);
        repeat (4) send_tick(CMD_NONE, 1'b0, 1'b0);
        send_tick(CMD_NONE, 1'b1, 1'b1);
        send_tick(CMD_NONE, 1'b0, 1'b0);
        send_tick(CMD_STOP, 1'b0, 1'b0);
    endtask

    task automatic test_config_extremes();
        set_config(16'd0, 16'd0, 32'd0);
        send_tick(CMD_DOWN, 1'b0, 1'b0);
        send_tick(CMD_NONE, 1'b0, 1'b0);
        send_tick(CMD_NONE, 1'b0, 1'b1);
        send_tick(CMD_NONE, 1'b0, 1'b0);
        send_tick(CMD_NONE, 1'b0, 1'b0);
        send_tick(CMD_UP, 1'b0, 1'b0);
        set_config(16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
        send_tick(CMD_DOWN, 1'b0, 1'b0);
        send_tick(CMD_NONE, 1'b0, 1'b0);
        send_tick(CMD_NONE, 1'b0, 1'b0);
        send_tick(CMD_STOP, 1'b0, 1'b0);
    endtask

    task automatic test_random_sender_light();
        set_config(16'($urandom_range(3)), 16'($urandom_range(8)), $urandom_range(30));
        snd_idle_pct = 15;
        rcv_idle_pct = 63;
        random_ticks(250);
    endtask

    task automatic test_random_receiver_light();
        set_config(16'($urandom_range(1, 6)), 16'($urandom_range(1, 12)),
                   $urandom_range(5, 200));
        snd_idle_pct = 63;
        rcv_idle_pct = 15;
        random_ticks(250);
    endtask

    task automatic test_random_no_idle();
        set_config(16'd0, 16'd1, 32'd10);
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        random_ticks(250);
    endtask

    task automatic test_backpressure();
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        hold_asked++;
        random_ticks(60);
    endtask

    initial
    begin
        rst_n      = 1'b0;
        cfg_we     = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        in_valid   = 1'b0;
        cmd        = CMD_NONE;
        limit_up   = 1'b0;
        limit_down = 1'b0;
        out_stall  = 1'b0;
        delay_ms   = CMD_DELAY_RST;
        warn_ms    = WARNING_TIME_RST;
        timeout_ms = TRAVEL_TIMEOUT_RST;
        tick_count = '0;
        last_up    = 1'b0;
        last_dn    = 1'b0;
        in_travel  = 1'b0;
        travel_t0  = '0;
        for (int i = 0; i < QUEUE_DEPTH; i++)
            act_fifo[i] = ACT_STOP_LO;
        fifo_clear();
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_values();
        test_directed();
        test_config_extremes();
        test_random_sender_light();
        test_random_receiver_light();
        test_random_no_idle();
        test_backpressure();

        drain();
        repeat (8) @(posedge clk);
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
